/* rtl/core/quadratic_root_solver_assert.svh */
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define QRS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);
`else
`define QRS_ASSERT_IMPL(lbl, pre, post, msg)
`define QRS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/qrs_pkg.sv */
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

    localparam int DISC_OUT_WIDTH = 34;
    localparam int VALUE_WIDTH    = 32;
    localparam int FRAC_SHIFT     = 16;

    typedef enum logic [1:0] {
        KIND_TWO_REAL   = 2'd0,
        KIND_ONE_REAL   = 2'd1,
        KIND_COMPLEX    = 2'd2,
        KIND_DEGENERATE = 2'd3
    } root_kind_t;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

endpackage

/* rtl/core/quadratic_root_solver.sv */
// Top level of the pipelined quadratic root solver.
//
// Use: an item of coefficients a, b and c (signed, 8 fraction bits) enters on the
// s_ channel (s_valid/s_ready); one result item leaves on the m_ channel
// (m_valid/m_ready) per input item, in order: root kind, the discriminant
// b*b - 4ac in Q18.16, two Q16.16 values and a saturation flag.
// Throughput is one item per cycle while the receiver takes results. The stages
// are the discriminant stages (2), the square root pipeline (one stage per root
// bit, COEF_WIDTH + 1), the numerator stage (1), the divider pipeline (one stage
// per quotient bit, COEF_WIDTH + 18) and the output register (1).
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken; while the receiver stalls, s_ready is low and
// every stage holds its item, so nothing is lost or repeated.
// A synchronous reset (aresetn low) clears all valid bits; data is not cleared.
// When a is zero the result is degenerate: both values and the flag are zero.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [COEF_WIDTH-1:0]                s_coef_a,
    input  logic signed [COEF_WIDTH-1:0]                s_coef_b,
    input  logic signed [COEF_WIDTH-1:0]                s_coef_c,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [1:0]                                  m_root_kind,
    output logic signed [qrs_pkg::DISC_OUT_WIDTH-1:0]   m_discriminant,
    output logic signed [qrs_pkg::VALUE_WIDTH-1:0]      m_first_value,
    output logic signed [qrs_pkg::VALUE_WIDTH-1:0]      m_second_value,
    output logic                                        m_saturated
);
    import qrs_pkg::*;

    `include "quadratic_root_solver_assert.svh"

    localparam int W   = COEF_WIDTH;
    localparam int NW  = W + 2;
    localparam int QW  = NW + FRAC_SHIFT;
    localparam int QXW = (QW > VALUE_WIDTH + 1) ? QW : VALUE_WIDTH + 1;
    localparam logic [QXW-1:0] POS_LIMIT = QXW'(VALUE_MAX);
    localparam logic [QXW-1:0] NEG_LIMIT = QXW'(VALUE_MAX) + QXW'(1);

    typedef struct packed {
        root_kind_t                kind;
        logic [DISC_OUT_WIDTH-1:0] disc;
        logic signed [W-1:0]       b;
        logic                      a_neg;
        logic [W:0]                den;
    } sq_sb_t;

    typedef struct packed {
        root_kind_t                kind;
        logic [DISC_OUT_WIDTH-1:0] disc;
        logic                      neg1;
        logic                      neg2;
    } div_sb_t;

    logic adv;

    logic                      dc_vld;
    root_kind_t                dc_kind;
    logic [DISC_OUT_WIDTH-1:0] dc_disc;
    logic [2*W+1:0]            dc_dmag;
    logic signed [W-1:0]       dc_b;
    logic                      dc_a_neg;
    logic [W:0]                dc_den;
    sq_sb_t                    sq_sb_in, sq_sb_out;
    logic                      sq_vld;
    logic [W:0]                sq_root;

    logic                      pr_vld_reg;
    logic [1:0][NW-1:0]        pr_num_reg;
    logic [W:0]                pr_den_reg;
    div_sb_t                   pr_sb_reg;
    logic signed [W+2:0]       nb_next, sx_next, n1_next, n2_next;
    logic [1:0][NW-1:0]        num_next;
    div_sb_t                   pr_sb_next;

    logic                      dv_vld;
    logic [1:0][QW-1:0]        dv_quo;
    div_sb_t                   dv_sb;

    logic                      out_vld_reg;
    logic [1:0]                kind_reg;
    logic [DISC_OUT_WIDTH-1:0] disc_reg;
    logic signed [VALUE_WIDTH-1:0] first_reg, second_reg;
    logic                      sat_reg;
    logic signed [VALUE_WIDTH-1:0] first_next, second_next;
    logic                      sat1_next, sat2_next, sat_next;

    // Whole-pipeline advance: the output register is free or being emptied.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    qrs_disc #(.W(W)) u_disc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_valid),
        .a       (s_coef_a),
        .b       (s_coef_b),
        .c       (s_coef_c),
        .out_vld (dc_vld),
        .kind    (dc_kind),
        .disc    (dc_disc),
        .dmag    (dc_dmag),
        .b_out   (dc_b),
        .a_neg   (dc_a_neg),
        .den_mag (dc_den)
    );

    assign sq_sb_in = '{kind: dc_kind, disc: dc_disc, b: dc_b, a_neg: dc_a_neg, den: dc_den};

    qrs_sqrt #(.W(W), .SBW($bits(sq_sb_t))) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (dc_vld),
        .rad     (dc_dmag),
        .sb_in   (sq_sb_in),
        .out_vld (sq_vld),
        .root    (sq_root),
        .sb_out  (sq_sb_out)
    );

    // Numerator stage: pick the two numerators and split them into sign and magnitude.
    always_comb begin
        nb_next = -(W+3)'(sq_sb_out.b);
        sx_next = signed'((W+3)'(sq_root));
        if (sq_sb_out.kind == KIND_COMPLEX) begin
            n1_next = nb_next;
            n2_next = sx_next;
        end else begin
            n1_next = nb_next + sx_next;
            n2_next = nb_next - sx_next;
        end
        num_next[0] = n1_next[W+2] ? NW'(-n1_next) : NW'(n1_next);
        num_next[1] = n2_next[W+2] ? NW'(-n2_next) : NW'(n2_next);
        pr_sb_next.kind = sq_sb_out.kind;
        pr_sb_next.disc = sq_sb_out.disc;
        pr_sb_next.neg1 = n1_next[W+2] ^ sq_sb_out.a_neg;
        pr_sb_next.neg2 = n2_next[W+2] ^ sq_sb_out.a_neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg <= 1'b0;
        end else if (adv) begin
            pr_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_num_reg <= num_next;
            pr_den_reg <= sq_sb_out.den;
            pr_sb_reg  <= pr_sb_next;
        end
    end

    qrs_div #(.NW(NW), .DNW(W + 1), .SBW($bits(div_sb_t))) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (pr_vld_reg),
        .num     (pr_num_reg),
        .den     (pr_den_reg),
        .sb_in   (pr_sb_reg),
        .out_vld (dv_vld),
        .quo     (dv_quo),
        .sb_out  (dv_sb)
    );

    // Apply the sign and clamp a quotient magnitude to the signed 32-bit range.
    function automatic logic [VALUE_WIDTH:0] apply_sign(input logic [QW-1:0] q,
                                                        input logic neg);
        logic [QXW-1:0]         qx;
        logic                   sat;
        logic [VALUE_WIDTH-1:0] val;
        qx = QXW'(q);
        if (neg) begin
            sat = (qx > NEG_LIMIT);
            val = sat ? VALUE_MIN : VALUE_WIDTH'(-qx);
        end else begin
            sat = (qx > POS_LIMIT);
            val = sat ? VALUE_MAX : VALUE_WIDTH'(qx);
        end
        return {sat, val};
    endfunction

    always_comb begin
        {sat1_next, first_next}  = apply_sign(dv_quo[0], dv_sb.neg1);
        {sat2_next, second_next} = apply_sign(dv_quo[1], dv_sb.neg2);
        sat_next = sat1_next | sat2_next;
        if (dv_sb.kind == KIND_DEGENERATE) begin
            first_next  = '0;
            second_next = '0;
            sat_next    = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg   <= dv_sb.kind;
            disc_reg   <= dv_sb.disc;
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_root_kind    = kind_reg;
    assign m_discriminant = disc_reg;
    assign m_first_value  = first_reg;
    assign m_second_value = second_reg;
    assign m_saturated    = sat_reg;

    // Checks on the result item.
    `QRS_ASSERT_IMPL(a_degenerate_zero, m_valid && m_root_kind == KIND_DEGENERATE, m_first_value == '0 && m_second_value == '0, "degenerate item with nonzero values")
    `QRS_ASSERT_IMPL(a_single_root_copy, m_valid && m_root_kind == KIND_ONE_REAL, m_first_value == m_second_value, "single root values differ")
    `QRS_ASSERT_IMPL(a_sat_at_limit, m_valid && m_saturated, m_first_value == VALUE_MAX || m_first_value == VALUE_MIN || m_second_value == VALUE_MAX || m_second_value == VALUE_MIN, "saturation flag without a clamped value")
    `QRS_ASSERT_NEVER(a_degenerate_no_sat, m_valid && m_root_kind == KIND_DEGENERATE && m_saturated, "degenerate item flagged as saturated")

endmodule

/* rtl/core/qrs_disc.sv */
// Discriminant stages: products, then b*b - 4ac with classification.
module qrs_disc #(
    parameter int W = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 in_vld,
    input  logic signed [W-1:0]                  a,
    input  logic signed [W-1:0]                  b,
    input  logic signed [W-1:0]                  c,
    output logic                                 out_vld,
    output qrs_pkg::root_kind_t                  kind,
    output logic [qrs_pkg::DISC_OUT_WIDTH-1:0]   disc,
    output logic [2*W+1:0]                       dmag,
    output logic signed [W-1:0]                  b_out,
    output logic                                 a_neg,
    output logic [W:0]                           den_mag
);
    import qrs_pkg::*;

    localparam int DW = 2 * W + 2;
    localparam int DX = (DW > DISC_OUT_WIDTH) ? DW : DISC_OUT_WIDTH;

    logic                  vld1_reg;
    logic signed [2*W-1:0] bb_reg, ac_reg;
    logic signed [2*W-1:0] bb_next, ac_next;
    logic signed [W-1:0]   a1_reg, b1_reg;

    logic                  vld2_reg;
    logic signed [DW-1:0]  d_next;
    logic [DW-1:0]         dmag_next;
    logic signed [DX-1:0]  dx_next;
    root_kind_t            kind_next, kind_reg;
    logic [DISC_OUT_WIDTH-1:0] disc_reg;
    logic [DW-1:0]         dmag_reg;
    logic signed [W-1:0]   b2_reg;
    logic                  aneg_reg;
    logic [W-1:0]          amag_next;
    logic [W:0]            den_reg;

    // First stage: the two products.
    assign bb_next = b * b;
    assign ac_next = a * c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bb_reg <= bb_next;
            ac_reg <= ac_next;
            a1_reg <= a;
            b1_reg <= b;
        end
    end

    // Second stage: exact discriminant, its magnitude and the root kind.
    always_comb begin
        d_next    = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        dmag_next = d_next[DW-1] ? DW'(-d_next) : DW'(d_next);
        dx_next   = DX'(d_next);
        amag_next = a1_reg[W-1] ? W'(-a1_reg) : W'(a1_reg);
        if (a1_reg == '0) begin
            kind_next = KIND_DEGENERATE;
        end else if (d_next == '0) begin
            kind_next = KIND_ONE_REAL;
        end else if (d_next[DW-1]) begin
            kind_next = KIND_COMPLEX;
        end else begin
            kind_next = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg <= kind_next;
            disc_reg <= dx_next[DISC_OUT_WIDTH-1:0];
            dmag_reg <= dmag_next;
            b2_reg   <= b1_reg;
            aneg_reg <= a1_reg[W-1];
            den_reg  <= {amag_next, 1'b0};
        end
    end

    assign out_vld = vld2_reg;
    assign kind    = kind_reg;
    assign disc    = disc_reg;
    assign dmag    = dmag_reg;
    assign b_out   = b2_reg;
    assign a_neg   = aneg_reg;
    assign den_mag = den_reg;

endmodule

/* rtl/core/qrs_sqrt.sv */
// Pipelined floored square root, one root bit per stage.
module qrs_sqrt #(
    parameter int W   = 16,
    parameter int SBW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [2*W+1:0]   rad,
    input  logic [SBW-1:0]   sb_in,
    output logic             out_vld,
    output logic [W:0]       root,
    output logic [SBW-1:0]   sb_out
);
    localparam int RT = W + 1;
    localparam int RW = 2 * RT;
    localparam int MW = RT + 1;

    logic           vld_reg  [RT];
    logic [RW-1:0]  rad_reg  [RT];
    logic [MW-1:0]  rem_reg  [RT];
    logic [RT-1:0]  root_reg [RT];
    logic [SBW-1:0] sb_reg   [RT];

    for (genvar k = 0; k < RT; k++) begin : g_stage
        localparam int P = RT - 1 - k;

        logic           vld_in;
        logic [RW-1:0]  rad_in;
        logic [MW-1:0]  rem_in;
        logic [RT-1:0]  root_in;
        logic [SBW-1:0] sb_stage_in;
        logic [MW+1:0]  shifted;
        logic [MW+1:0]  trial;
        logic           ge;
        logic [MW-1:0]  rem_next;
        logic [RT-1:0]  root_next;

        if (k == 0) begin : g_first
            assign vld_in      = in_vld;
            assign rad_in      = rad;
            assign rem_in      = '0;
            assign root_in     = '0;
            assign sb_stage_in = sb_in;
        end else begin : g_next
            assign vld_in      = vld_reg[k-1];
            assign rad_in      = rad_reg[k-1];
            assign rem_in      = rem_reg[k-1];
            assign root_in     = root_reg[k-1];
            assign sb_stage_in = sb_reg[k-1];
        end

        // Bring down the next bit pair and try the trial subtrahend.
        always_comb begin
            shifted   = {rem_in, rad_in[2*P+1:2*P]};
            trial     = (MW+2)'({root_in, 2'b01});
            ge        = (shifted >= trial);
            rem_next  = ge ? MW'(shifted - trial) : MW'(shifted);
            root_next = {root_in[RT-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sb_reg[k]   <= sb_stage_in;
            end
        end
    end

    assign out_vld = vld_reg[RT-1];
    assign root    = root_reg[RT-1];
    assign sb_out  = sb_reg[RT-1];

endmodule

/* rtl/core/qrs_div.sv */
// Pipelined two-lane restoring divider of (n * 2^16) by a shared divisor.
module qrs_div #(
    parameter int NW  = 18,
    parameter int DNW = 17,
    parameter int SBW = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_vld,
    input  logic [1:0][NW-1:0]                     num,
    input  logic [DNW-1:0]                         den,
    input  logic [SBW-1:0]                         sb_in,
    output logic                                   out_vld,
    output logic [1:0][NW+qrs_pkg::FRAC_SHIFT-1:0] quo,
    output logic [SBW-1:0]                         sb_out
);
    import qrs_pkg::*;

    localparam int QW = NW + FRAC_SHIFT;

    logic                  vld_reg [QW];
    logic [1:0][NW-1:0]    num_reg [QW];
    logic [DNW-1:0]        den_reg [QW];
    logic [1:0][DNW-1:0]   rem_reg [QW];
    logic [1:0][QW-1:0]    quo_reg [QW];
    logic [SBW-1:0]        sb_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int J = QW - 1 - k;

        logic                vld_in;
        logic [1:0][NW-1:0]  num_in;
        logic [DNW-1:0]      den_in;
        logic [1:0][DNW-1:0] rem_in;
        logic [1:0][QW-1:0]  quo_in;
        logic [SBW-1:0]      sb_stage_in;
        logic [1:0][DNW-1:0] rem_next;
        logic [1:0][QW-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign vld_in      = in_vld;
            assign num_in      = num;
            assign den_in      = den;
            assign rem_in      = '0;
            assign quo_in      = '0;
            assign sb_stage_in = sb_in;
        end else begin : g_next
            assign vld_in      = vld_reg[k-1];
            assign num_in      = num_reg[k-1];
            assign den_in      = den_reg[k-1];
            assign rem_in      = rem_reg[k-1];
            assign quo_in      = quo_reg[k-1];
            assign sb_stage_in = sb_reg[k-1];
        end

        // One quotient bit per lane; the low dividend bits are the zero fraction.
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic          dbit;
            logic [DNW:0]  shifted;
            logic          ge;

            if (J >= FRAC_SHIFT) begin : g_numbit
                assign dbit = num_in[l][J-FRAC_SHIFT];
            end else begin : g_zerobit
                assign dbit = 1'b0;
            end

            always_comb begin
                shifted     = {rem_in[l], dbit};
                ge          = (shifted >= (DNW+1)'(den_in));
                rem_next[l] = ge ? DNW'(shifted - (DNW+1)'(den_in)) : DNW'(shifted);
                quo_next[l] = {quo_in[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                num_reg[k] <= num_in;
                den_reg[k] <= den_in;
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                sb_reg[k]  <= sb_stage_in;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quo     = quo_reg[QW-1];
    assign sb_out  = sb_reg[QW-1];

endmodule

/* tb/tb_quadratic_root_solver.sv */
// Self-checking testbench for the quadratic root solver, with its scoreboard class.
module tb_quadratic_root_solver;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    // One predicted result item.
    typedef struct {
        root_kind_t                   kind;
        logic signed [DISC_OUT_WIDTH-1:0] disc;
        logic signed [VALUE_WIDTH-1:0]    first;
        logic signed [VALUE_WIDTH-1:0]    second;
        logic                             sat;
    } roots_t;

    // Scoreboard: predicts the roots of each accepted item and checks results in order.
    class roots_scoreboard;
        roots_t pending_roots[$];
        int     errors = 0;

        static function automatic longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned bitv;
            r = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= r + bitv) begin
                    n = n - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        // Truncating Q16.16 quotient, clamped to the 32-bit signed range.
        function automatic logic signed [VALUE_WIDTH-1:0] scaled_quotient(longint num,
                longint den, ref logic sat);
            longint q;
            q = (num * 65536) / den;
            if (q > 64'sd2147483647) begin
                sat = 1'b1;
                return VALUE_MAX;
            end
            if (q < -64'sd2147483648) begin
                sat = 1'b1;
                return VALUE_MIN;
            end
            return q[VALUE_WIDTH-1:0];
        endfunction

        function void note_item(logic signed [15:0] a, logic signed [15:0] b,
                logic signed [15:0] c);
            roots_t r;
            longint d;
            longint s;
            longint ai;
            longint bi;
            logic sat;
            ai = longint'(a);
            bi = longint'(b);
            d = bi * bi - 4 * ai * longint'(c);
            sat = 1'b0;
            r.disc = d[DISC_OUT_WIDTH-1:0];
            r.first = '0;
            r.second = '0;
            s = floor_sqrt(d < 0 ? -d : d);
            if (a == 0) begin
                r.kind = KIND_DEGENERATE;
            end else if (d == 0) begin
                r.kind = KIND_ONE_REAL;
                r.first = scaled_quotient(-bi, 2 * ai, sat);
                r.second = r.first;
            end else if (d > 0) begin
                r.kind = KIND_TWO_REAL;
                r.first = scaled_quotient(-bi + s, 2 * ai, sat);
                r.second = scaled_quotient(-bi - s, 2 * ai, sat);
            end else begin
                r.kind = KIND_COMPLEX;
                r.first = scaled_quotient(-bi, 2 * ai, sat);
                r.second = scaled_quotient(s, 2 * ai, sat);
            end
            r.sat = sat;
            pending_roots.push_back(r);
        endfunction

        function void check_result(logic [1:0] kind, logic signed [DISC_OUT_WIDTH-1:0] disc,
                logic signed [VALUE_WIDTH-1:0] first, logic signed [VALUE_WIDTH-1:0] second,
                logic sat);
            roots_t e;
            if (pending_roots.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
                return;
            end
            e = pending_roots.pop_front();
            if (kind !== e.kind) begin
                $error("root_kind: expected %0d, got %0d", e.kind, kind);
                errors++;
            end
            if (disc !== e.disc) begin
                $error("discriminant: expected %0d, got %0d", e.disc, disc);
                errors++;
            end
            if (first !== e.first) begin
                $error("first_value: expected %0d, got %0d", e.first, first);
                errors++;
            end
            if (second !== e.second) begin
                $error("second_value: expected %0d, got %0d", e.second, second);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0d, got %0d", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [15:0]               s_coef_a = '0;
    logic signed [15:0]               s_coef_b = '0;
    logic signed [15:0]               s_coef_c = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [1:0]                       m_root_kind;
    logic signed [DISC_OUT_WIDTH-1:0] m_discriminant;
    logic signed [VALUE_WIDTH-1:0]    m_first_value;
    logic signed [VALUE_WIDTH-1:0]    m_second_value;
    logic                             m_saturated;

    roots_scoreboard sb = new();
    bit idling = 1'b1;

    quadratic_root_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_kind(m_root_kind), .m_discriminant(m_discriminant),
        .m_first_value(m_first_value), .m_second_value(m_second_value),
        .m_saturated(m_saturated)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Offers one item from a falling edge, waits until it is taken, then maybe idles.
    task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
            logic signed [15:0] c);
        int gap;
        s_valid = 1'b1;
        s_coef_a = a;
        s_coef_b = b;
        s_coef_c = c;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_item(a, b, c);
        @(negedge aclk);
        gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Random coefficient set: mostly free, with shapes that hit each root kind.
    task automatic send_random();
        int p;
        int q;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                // Perfect square: one real root unless p is zero.
                p = $urandom_range(0, 127);
                q = $urandom_range(0, 127);
                a = 16'(p * p);
                c = 16'(q * q);
                b = 16'($urandom_range(0, 1) ? 2 * p * q : -2 * p * q);
                if ($urandom_range(0, 1)) begin
                    a = -a;
                    c = -c;
                end
            end
            1: a = 16'sd0;
            2: a = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            3: b = $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: ;
        endcase
        send_coefs(a, b, c);
    endtask

    // Receiver: ready drops in random bursts, none in the last part of the run.
    initial begin
        int burst;
        forever begin
            @(negedge aclk);
            if (idling && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15);
                m_ready = 1'b0;
                repeat (burst) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Result checking at the rising edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_root_kind, m_discriminant, m_first_value,
                                m_second_value, m_saturated);
        end
    end

    // Stimulus and end of run.
    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: degenerate, each root kind, negative a, saturation, extremes.
        send_coefs(16'sd0, 16'sd512, 16'sd300);
        send_coefs(16'sd0, -16'sd32768, 16'sd0);
        send_coefs(16'sd256, 16'sd512, 16'sd256);
        send_coefs(-16'sd256, 16'sd512, -16'sd256);
        send_coefs(16'sd256, -16'sd768, 16'sd512);
        send_coefs(16'sd256, 16'sd0, 16'sd256);
        send_coefs(-16'sd256, 16'sd256, -16'sd1024);
        send_coefs(16'sd1, -16'sd32768, 16'sd0);
        send_coefs(-16'sd1, 16'sd32767, 16'sd1);
        send_coefs(16'sd1, 16'sd0, 16'sd32767);
        send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
        send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
        send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
        send_coefs(16'sd32767, 16'sd0, -16'sd32768);
        send_coefs(-16'sd1, -16'sd1, -16'sd1);
        send_coefs(16'sd1, 16'sd2, 16'sd1);
        send_coefs(16'sd0, 16'sd0, 16'sd0);

        // Pause until every expected result has come back.
        s_valid = 1'b0;
        while (sb.pending_roots.size() != 0) @(negedge aclk);

        repeat (1100) send_random();
        idling = 1'b0;
        repeat (200) send_random();
        s_valid = 1'b0;

        while (sb.pending_roots.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_roots.size() == 0) begin
            $display("quadratic_root_solver verification clean");
        end else begin
            $display("quadratic_root_solver verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("quadratic_root_solver verification failed");
        $finish;
    end
endmodule
